// ===== hw/rtl/srr_pkg.sv =====
// shared types, codes and reset values for the stereo reprojection residual unit
// no dependencies; used by the top level and the checker
package srr_pkg;

  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] CfgBaseline = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgFocal    = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgCenterX  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgCenterY  = CfgIdxW'(3);

  localparam logic [15:0] BaselineRst = 16'd2212;
  localparam logic [15:0] FocalRst    = 16'd11502;
  localparam logic [15:0] CenterXRst  = 16'd9715;
  localparam logic [15:0] CenterYRst  = 16'd2963;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StZeroDisp  = 2'd1,
    StZeroDepth = 2'd2,
    StSat       = 2'd3
  } srr_status_e;

  typedef struct packed {
    logic [15:0]        left_u;
    logic [15:0]        left_v;
    logic [15:0]        right_u;
    logic [15:0]        right_v;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } srr_in_t;

  typedef struct packed {
    logic signed [31:0] resid_u;
    logic signed [31:0] resid_v;
    srr_status_e        status;
  } srr_out_t;

  // rides along the rotation divider
  typedef struct packed {
    logic [36:0] numa_x;
    logic [36:0] numa_y;
    logic [36:0] numa_z;
    logic [16:0] disp;
    logic        dzero;
    logic [31:0] tx;
    logic [31:0] ty;
    logic [31:0] tz;
    logic [15:0] ur;
    logic [15:0] vr;
  } srr_side_b_t;

  // rides along the triangulation divider
  typedef struct packed {
    logic [8:0][25:0] rot;
    logic [31:0]      tx;
    logic [31:0]      ty;
    logic [31:0]      tz;
    logic [15:0]      ur;
    logic [15:0]      vr;
    logic             dzero;
  } srr_side_a_t;

  // rides along the projection divider
  typedef struct packed {
    logic [15:0] ur;
    logic [15:0] vr;
    logic        dzero;
    logic        pzero;
  } srr_side_c_t;

endpackage

// ===== hw/rtl/srr_div.sv =====
// pipelined signed divider, one quotient bit per stage, lanes share one divisor
// uses no package; instantiated by the top level
module srr_div #(
  parameter int unsigned NW = 36,
  parameter int unsigned DW = 16,
  parameter int unsigned L  = 1,
  parameter int unsigned SW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [L-1:0][NW:0]  num_i,
  input  logic [DW:0]         den_i,
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output logic [L-1:0][NW:0]  quot_o,
  output logic [SW-1:0]       side_o
);

  logic [NW:0]                    vld_q;
  logic [NW-1:0][L-1:0][DW-1:0]   rem_q, rem_d;
  logic [NW:0][L-1:0][NW-1:0]     wrk_q, wrk_d;
  logic [NW:0][L-1:0]             neg_q, neg_d;
  logic [NW:0][DW-1:0]            dv_q, dv_d;
  logic [NW:0][SW-1:0]            sd_q, sd_d;

  always_comb begin
    logic [NW:0] na;
    logic [DW:0] da;
    logic [DW:0] rs;
    logic [DW:0] rd;
    logic        ge;
    rem_d = '0;
    da = den_i[DW] ? (~den_i + 1'b1) : den_i;
    dv_d[0] = da[DW-1:0];
    sd_d[0] = side_i;
    for (int l = 0; l < L; l++) begin
      na = num_i[l][NW] ? (~num_i[l] + 1'b1) : num_i[l];
      wrk_d[0][l] = na[NW-1:0];
      neg_d[0][l] = num_i[l][NW] ^ den_i[DW];
    end
    for (int k = 1; k <= NW; k++) begin
      dv_d[k]  = dv_q[k-1];
      sd_d[k]  = sd_q[k-1];
      neg_d[k] = neg_q[k-1];
      for (int l = 0; l < L; l++) begin
        rs = {rem_q[k-1][l], wrk_q[k-1][l][NW-1]};
        rd = rs - {1'b0, dv_q[k-1]};
        ge = (rs >= {1'b0, dv_q[k-1]});
        if (k < NW) begin
          rem_d[k][l] = ge ? rd[DW-1:0] : rs[DW-1:0];
        end
        wrk_d[k][l] = {wrk_q[k-1][l][NW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      wrk_q <= wrk_d;
      neg_q <= neg_d;
      dv_q  <= dv_d;
      sd_q  <= sd_d;
    end
  end

  always_comb begin
    for (int l = 0; l < L; l++) begin
      quot_o[l] = neg_q[NW][l] ? (~{1'b0, wrk_q[NW][l]} + 1'b1) : {1'b0, wrk_q[NW][l]};
    end
  end

  assign valid_o = vld_q[NW];
  assign side_o  = sd_q[NW];

endmodule

// ===== hw/rtl/stereo_reprojection_residual_unit.sv =====
// stereo reprojection residual: the path from word accepted to result valid is set by
// the three bit-serial divider pipelines (58, 37 and 60 stages) plus 9 stages
// of products, sums and output after the input register that loads on the accepting edge.
// throughput one word per cycle unless the output queue is full and stalled; a 2-entry output
// queue keeps input open while one result waits. rst_ni async active low clears
// valids, the output queue and loads the config reset values; no clearing pass.
// depends on srr_pkg and srr_div
module stereo_reprojection_residual_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  srr_pkg::srr_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output srr_pkg::srr_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [srr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);

  // divider geometry: magnitude bits of numerator and divisor
  localparam int unsigned BNW = 57;
  localparam int unsigned BDW = 33;
  localparam int unsigned ANW = 36;
  localparam int unsigned ADW = 16;
  localparam int unsigned CNW = 59;
  localparam int unsigned CDW = 39;
  localparam logic [BNW:0] RotOne = (BNW+1)'(24'd0) | ((BNW+1)'(1) << 24);

  logic adv;  // global pipeline advance

  // config registers
  logic [15:0] baseline_q, focal_q, center_x_q, center_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q <= srr_pkg::BaselineRst;
      focal_q    <= srr_pkg::FocalRst;
      center_x_q <= srr_pkg::CenterXRst;
      center_y_q <= srr_pkg::CenterYRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        srr_pkg::CfgBaseline: baseline_q <= cfg_data_i;
        srr_pkg::CfgFocal:    focal_q    <= cfg_data_i;
        srr_pkg::CfgCenterX:  center_x_q <= cfg_data_i;
        srr_pkg::CfgCenterY:  center_y_q <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // s0: input word register
  logic             v0_q;
  srr_pkg::srr_in_t in_q;

  assign in_ready_o = adv;

  // ---------------------------------------------------------------------
  // s1: disparity, triangulation numerators, quaternion products
  logic               v1_q;
  logic signed [16:0] disp1_q;
  logic signed [33:0] numx1_q, numy1_q;
  logic [31:0]        numz1_q;
  logic signed [31:0] ww1_q, xx1_q, yy1_q, zz1_q, xy1_q, wz1_q, xz1_q, wy1_q, yz1_q, wx1_q;
  logic [31:0]        tx1_q, ty1_q, tz1_q;
  logic [15:0]        ur1_q, vr1_q;

  logic signed [16:0] du1, dv1, b17;
  assign du1 = $signed({1'b0, in_q.left_u}) - $signed({1'b0, center_x_q});
  assign dv1 = $signed({1'b0, in_q.left_v}) - $signed({1'b0, center_y_q});
  assign b17 = $signed({1'b0, baseline_q});

  // ---------------------------------------------------------------------
  // s2: rotation matrix numerators and squared norm
  logic               v2_q;
  logic signed [33:0] m2_q [9];
  logic signed [33:0] n2_q;
  logic [36:0]        numax2_q, numay2_q, numaz2_q;
  logic [16:0]        disp2_q;
  logic               dzero2_q;
  logic [31:0]        tx2_q, ty2_q, tz2_q;
  logic [15:0]        ur2_q, vr2_q;

  // ---------------------------------------------------------------------
  // rotation divider: r = m * 2^24 / n
  logic [8:0][BNW:0]    num_b, quot_b;
  logic [BDW:0]         den_b;
  srr_pkg::srr_side_b_t side_b_in, side_b_out;
  logic                 vb;
  logic                 nzero2;

  assign nzero2 = (n2_q == '0);

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      if (nzero2) begin
        // degenerate quaternion, identity rotation
        num_b[k] = (k == 0 || k == 4 || k == 8) ? RotOne : '0;
      end else begin
        num_b[k] = {m2_q[k], 24'd0};
      end
    end
  end

  assign den_b = nzero2 ? (BDW+1)'(1) : n2_q;

  assign side_b_in = '{numa_x: numax2_q, numa_y: numay2_q, numa_z: numaz2_q,
                       disp: disp2_q, dzero: dzero2_q, tx: tx2_q, ty: ty2_q, tz: tz2_q,
                       ur: ur2_q, vr: vr2_q};

  srr_div #(.NW(BNW), .DW(BDW), .L(9), .SW($bits(srr_pkg::srr_side_b_t))) u_div_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v2_q),
    .num_i   (num_b),
    .den_i   (den_b),
    .side_i  (side_b_in),
    .valid_o (vb),
    .quot_o  (quot_b),
    .side_o  (side_b_out)
  );

  // ---------------------------------------------------------------------
  // triangulation divider: point = numerator / disparity
  logic [2:0][ANW:0]    num_a, quot_a;
  logic [ADW:0]         den_a;
  srr_pkg::srr_side_a_t side_a_in, side_a_out;
  logic                 va;

  assign num_a = {side_b_out.numa_z, side_b_out.numa_y, side_b_out.numa_x};
  assign den_a = side_b_out.dzero ? (ADW+1)'(1) : side_b_out.disp;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      side_a_in.rot[k] = quot_b[k][25:0];
    end
    side_a_in.tx    = side_b_out.tx;
    side_a_in.ty    = side_b_out.ty;
    side_a_in.tz    = side_b_out.tz;
    side_a_in.ur    = side_b_out.ur;
    side_a_in.vr    = side_b_out.vr;
    side_a_in.dzero = side_b_out.dzero;
  end

  srr_div #(.NW(ANW), .DW(ADW), .L(3), .SW($bits(srr_pkg::srr_side_a_t))) u_div_tri (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vb),
    .num_i   (num_a),
    .den_i   (den_a),
    .side_i  (side_a_in),
    .valid_o (va),
    .quot_o  (quot_a),
    .side_o  (side_a_out)
  );

  // ---------------------------------------------------------------------
  // m1..m4: rotate and translate, 26x37 products split in two halves
  logic               v3_q, v4_q, v5_q, v6_q;
  logic signed [45:0] pl3_q [9];
  logic signed [43:0] ph3_q [9];
  logic signed [63:0] pr4_q [9];
  logic signed [63:0] acc5_q [3];
  logic signed [39:0] pc6_q [3];
  logic [31:0]        t3_q [3], t4_q [3], t5_q [3];
  logic [15:0]        ur3_q, vr3_q, ur4_q, vr4_q, ur5_q, vr5_q, ur6_q, vr6_q;
  logic               dz3_q, dz4_q, dz5_q, dz6_q;

  // m5, m6: projection numerators
  logic               v7_q, v8_q;
  logic signed [37:0] pfl7_q [2];
  logic signed [36:0] pfh7_q [2];
  logic signed [39:0] pcz7_q, denc8_q;
  logic               pz7_q, pz8_q;
  logic [15:0]        ur7_q, vr7_q, ur8_q, vr8_q;
  logic               dz7_q, dz8_q;
  logic [1:0][CNW:0]  numc8_q;

  logic signed [16:0] f17;
  assign f17 = $signed({1'b0, focal_q});

  // ---------------------------------------------------------------------
  // projection divider
  logic [1:0][CNW:0]    quot_c;
  srr_pkg::srr_side_c_t side_c_in, side_c_out;
  logic                 vc;

  assign side_c_in = '{ur: ur8_q, vr: vr8_q, dzero: dz8_q, pzero: pz8_q};

  srr_div #(.NW(CNW), .DW(CDW), .L(2), .SW($bits(srr_pkg::srr_side_c_t))) u_div_prj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v8_q),
    .num_i   (numc8_q),
    .den_i   (denc8_q),
    .side_i  (side_c_in),
    .valid_o (vc),
    .quot_o  (quot_c),
    .side_o  (side_c_out)
  );

  // ---------------------------------------------------------------------
  // residuals, saturation and status
  logic signed [61:0] ru, rv;
  logic               sat_u, sat_v;
  srr_pkg::srr_out_t  res;

  always_comb begin
    ru = 62'($signed(quot_c[0])) + $signed({42'd0, center_x_q, 4'd0})
         - $signed({42'd0, side_c_out.ur, 4'd0});
    rv = 62'($signed(quot_c[1])) + $signed({42'd0, center_y_q, 4'd0})
         - $signed({42'd0, side_c_out.vr, 4'd0});
    sat_u = !((&ru[61:31]) || !(|ru[61:31]));
    sat_v = !((&rv[61:31]) || !(|rv[61:31]));
    res.resid_u = sat_u ? (ru[61] ? 32'sh8000_0000 : 32'sh7fff_ffff) : ru[31:0];
    res.resid_v = sat_v ? (rv[61] ? 32'sh8000_0000 : 32'sh7fff_ffff) : rv[31:0];
    res.status  = srr_pkg::StOk;
    if (side_c_out.dzero) begin
      res.resid_u = '0;
      res.resid_v = '0;
      res.status  = srr_pkg::StZeroDisp;
    end else if (side_c_out.pzero) begin
      res.resid_u = '0;
      res.resid_v = '0;
      res.status  = srr_pkg::StZeroDepth;
    end else if (sat_u || sat_v) begin
      res.status  = srr_pkg::StSat;
    end
  end

  // ---------------------------------------------------------------------
  // 2-entry output queue, e0 is the head shown on the port
  srr_pkg::srr_out_t e0_q, e0_d, e1_q, e1_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              push, pop;

  assign adv         = (cnt_q != 2'd2) || out_ready_i;
  assign push        = vc && adv;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = e0_q;

  always_comb begin
    logic [1:0] left;
    e0_d  = e0_q;
    e1_d  = e1_q;
    left  = cnt_q - {1'b0, pop};
    if (pop) begin
      e0_d = e1_q;
    end
    if (push) begin
      if (left == 2'd0) begin
        e0_d = res;
      end else begin
        e1_d = res;
      end
    end
    cnt_d = left + {1'b0, push};
  end

  // ---------------------------------------------------------------------
  // valid chain and queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (adv) begin
        v0_q <= in_valid_i;
        v1_q <= v0_q;
        v2_q <= v1_q;
        v3_q <= va;
        v4_q <= v3_q;
        v5_q <= v4_q;
        v6_q <= v5_q;
        v7_q <= v6_q;
        v8_q <= v7_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

  // ---------------------------------------------------------------------
  // datapath registers, all held while the pipeline stalls
  always_ff @(posedge clk_i) begin
    logic signed [63:0] biased;
    logic signed [63:0] shifted;
    if (adv) begin
      // s0
      in_q <= in_data_i;

      // s1
      disp1_q <= $signed({1'b0, in_q.left_u}) - $signed({1'b0, in_q.right_u});
      numx1_q <= du1 * b17;
      numy1_q <= dv1 * b17;
      numz1_q <= focal_q * baseline_q;
      ww1_q   <= in_q.quat_w * in_q.quat_w;
      xx1_q   <= in_q.quat_x * in_q.quat_x;
      yy1_q   <= in_q.quat_y * in_q.quat_y;
      zz1_q   <= in_q.quat_z * in_q.quat_z;
      xy1_q   <= in_q.quat_x * in_q.quat_y;
      wz1_q   <= in_q.quat_w * in_q.quat_z;
      xz1_q   <= in_q.quat_x * in_q.quat_z;
      wy1_q   <= in_q.quat_w * in_q.quat_y;
      yz1_q   <= in_q.quat_y * in_q.quat_z;
      wx1_q   <= in_q.quat_w * in_q.quat_x;
      tx1_q   <= in_q.trans_x;
      ty1_q   <= in_q.trans_y;
      tz1_q   <= in_q.trans_z;
      ur1_q   <= in_q.right_u;
      vr1_q   <= in_q.right_v;

      // s2
      m2_q[0]  <= 34'(ww1_q) + 34'(xx1_q) - 34'(yy1_q) - 34'(zz1_q);
      m2_q[1]  <= (34'(xy1_q) - 34'(wz1_q)) <<< 1;
      m2_q[2]  <= (34'(xz1_q) + 34'(wy1_q)) <<< 1;
      m2_q[3]  <= (34'(xy1_q) + 34'(wz1_q)) <<< 1;
      m2_q[4]  <= 34'(ww1_q) - 34'(xx1_q) + 34'(yy1_q) - 34'(zz1_q);
      m2_q[5]  <= (34'(yz1_q) - 34'(wx1_q)) <<< 1;
      m2_q[6]  <= (34'(xz1_q) - 34'(wy1_q)) <<< 1;
      m2_q[7]  <= (34'(yz1_q) + 34'(wx1_q)) <<< 1;
      m2_q[8]  <= 34'(ww1_q) - 34'(xx1_q) - 34'(yy1_q) + 34'(zz1_q);
      n2_q     <= 34'(ww1_q) + 34'(xx1_q) + 34'(yy1_q) + 34'(zz1_q);
      numax2_q <= {numx1_q[32:0], 4'd0};
      numay2_q <= {numy1_q[32:0], 4'd0};
      numaz2_q <= {1'b0, numz1_q, 4'd0};
      disp2_q  <= disp1_q;
      dzero2_q <= (disp1_q == '0);
      tx2_q    <= tx1_q;
      ty2_q    <= ty1_q;
      tz2_q    <= tz1_q;
      ur2_q    <= ur1_q;
      vr2_q    <= vr1_q;

      // m1: split partial products of r * p
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pl3_q[3*i+j] <= $signed(side_a_out.rot[3*i+j]) * $signed({1'b0, quot_a[j][18:0]});
          ph3_q[3*i+j] <= $signed(side_a_out.rot[3*i+j]) * $signed(quot_a[j][36:19]);
        end
      end
      t3_q[0] <= side_a_out.tx;
      t3_q[1] <= side_a_out.ty;
      t3_q[2] <= side_a_out.tz;
      ur3_q   <= side_a_out.ur;
      vr3_q   <= side_a_out.vr;
      dz3_q   <= side_a_out.dzero;

      // m2: recombine halves
      for (int k = 0; k < 9; k++) begin
        pr4_q[k] <= (64'(ph3_q[k]) <<< 19) + 64'(pl3_q[k]);
      end
      t4_q  <= t3_q;
      ur4_q <= ur3_q;
      vr4_q <= vr3_q;
      dz4_q <= dz3_q;

      // m3: row sums
      for (int i = 0; i < 3; i++) begin
        acc5_q[i] <= pr4_q[3*i] + pr4_q[3*i+1] + pr4_q[3*i+2];
      end
      t5_q  <= t4_q;
      ur5_q <= ur4_q;
      vr5_q <= vr4_q;
      dz5_q <= dz4_q;

      // m4: scale down with truncation toward zero, add translation
      for (int i = 0; i < 3; i++) begin
        biased   = acc5_q[i] + {40'd0, {24{acc5_q[i][63]}}};
        shifted  = biased >>> 24;
        pc6_q[i] <= shifted[39:0] + 40'($signed(t5_q[i]));
      end
      ur6_q <= ur5_q;
      vr6_q <= vr5_q;
      dz6_q <= dz5_q;

      // m5: focal times camera point, split products
      for (int i = 0; i < 2; i++) begin
        pfl7_q[i] <= f17 * $signed({1'b0, pc6_q[i][19:0]});
        pfh7_q[i] <= f17 * $signed(pc6_q[i][39:20]);
      end
      pcz7_q <= pc6_q[2];
      pz7_q  <= (pc6_q[2] == '0);
      ur7_q  <= ur6_q;
      vr7_q  <= vr6_q;
      dz7_q  <= dz6_q;

      // m6: projection numerators, depth as divisor
      for (int i = 0; i < 2; i++) begin
        numc8_q[i] <= ((60'(pfh7_q[i]) <<< 20) + 60'(pfl7_q[i])) <<< 4;
      end
      denc8_q <= pz7_q ? 40'sd1 : pcz7_q;
      pz8_q   <= pz7_q;
      ur8_q   <= ur7_q;
      vr8_q   <= vr7_q;
      dz8_q   <= dz7_q;
    end
  end

endmodule

// ===== hw/rtl/srr_checker.sv =====
// port-level checks for the stereo reprojection residual unit, bound to the top level
// depends on srr_pkg
module srr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input srr_pkg::srr_in_t              in_data_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input srr_pkg::srr_out_t             out_data_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [srr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input logic [15:0]                   cfg_data_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // input closes only when the output queue is full and stalled
  a_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without output backpressure");

  // degenerate geometry gives zero residuals
  a_zero_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == srr_pkg::StZeroDisp ||
                    out_data_o.status == srr_pkg::StZeroDepth)
    |-> out_data_o.resid_u == '0 && out_data_o.resid_v == '0)
    else $error("nonzero residual on degenerate word");

  // saturation leaves one residual at a limit
  a_sat_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == srr_pkg::StSat
    |-> out_data_o.resid_u == 32'sh7fff_ffff || out_data_o.resid_u == 32'sh8000_0000 ||
        out_data_o.resid_v == 32'sh7fff_ffff || out_data_o.resid_v == 32'sh8000_0000)
    else $error("saturated status without clamped residual");

endmodule

bind stereo_reprojection_residual_unit srr_checker u_srr_checker (.*);
